// File: design/range_assign_add_aggregate_tree_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RANGE_ASSIGN_ADD_AGGREGATE_TREE_ASSERT_SVH
`define RANGE_ASSIGN_ADD_AGGREGATE_TREE_ASSERT_SVH

// implication in the same cycle
`define RAAT_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("label failed");

// implication checked in the next cycle
`define RAAT_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("label failed");

`endif

// File: design/raat_pkg.sv
// ----------------------------------------------------------------------------
// raat_pkg
// Constants, node word layout, datapath command codes and status.
// ----------------------------------------------------------------------------
package raat_pkg;

  localparam int LEAVES = 1024;
  localparam int NODES  = 2 * LEAVES;
  localparam int PW     = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int LW     = $clog2(LEAVES + 1);
  localparam int NW     = $clog2(NODES);
  localparam int SD     = PW + 1;
  localparam int SIW    = $clog2(SD);
  localparam int SPW    = $clog2(SD + 1);

  localparam logic [1:0] OP_ASSIGN = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] MODE_MAX = 2'd1;
  localparam logic [1:0] MODE_MIN = 2'd2;

  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_DEFAULT = 2'd1;
  localparam logic [1:0] CFG_START   = 2'd2;
  localparam logic [1:0] CFG_END     = 2'd3;

  localparam int CW = 5;
  localparam logic [CW-1:0] DP_NOP      = 5'd0;
  localparam logic [CW-1:0] DP_LOAD     = 5'd1;
  localparam logic [CW-1:0] DP_SET_INIT = 5'd2;
  localparam logic [CW-1:0] DP_SET_COV  = 5'd3;
  localparam logic [CW-1:0] DP_SET_LC   = 5'd4;
  localparam logic [CW-1:0] DP_SET_RC   = 5'd5;
  localparam logic [CW-1:0] DP_AP_RD    = 5'd6;
  localparam logic [CW-1:0] DP_AP_X     = 5'd7;
  localparam logic [CW-1:0] DP_AP_MUL   = 5'd8;
  localparam logic [CW-1:0] DP_AP_WR    = 5'd9;
  localparam logic [CW-1:0] DP_RD_N     = 5'd10;
  localparam logic [CW-1:0] DP_PD_LATCH = 5'd11;
  localparam logic [CW-1:0] DP_ACC      = 5'd12;
  localparam logic [CW-1:0] DP_RD_LC    = 5'd13;
  localparam logic [CW-1:0] DP_RD_RC    = 5'd14;
  localparam logic [CW-1:0] DP_COMB_WR  = 5'd15;
  localparam logic [CW-1:0] DP_DESC_L   = 5'd16;
  localparam logic [CW-1:0] DP_DESC_R   = 5'd17;
  localparam logic [CW-1:0] DP_PH_INC   = 5'd18;
  localparam logic [CW-1:0] DP_POP      = 5'd19;
  localparam logic [CW-1:0] DP_DONE     = 5'd20;

  typedef struct packed {
    logic        flag;
    logic [31:0] asgv;
    logic [31:0] padd;
    logic [31:0] agg;
  } node_t;

  typedef struct packed {
    logic       cfg_hit;
    logic       err;
    logic       op_none;
    logic       is_query;
    logic       covered;
    logic       go_left;
    logic       go_right;
    logic [1:0] phase;
    logic       sp_zero;
  } status_t;

endpackage

// File: design/raat_ctrl.sv
// ----------------------------------------------------------------------------
// raat_ctrl
// Sequencer: walks the tree and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module raat_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  raat_pkg::status_t    st,
  output logic [raat_pkg::CW-1:0] cmd,
  output logic                 busy
);
  import raat_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_AP_RD  = 5'd2;
  localparam logic [4:0] S_AP_X   = 5'd3;
  localparam logic [4:0] S_AP_MUL = 5'd4;
  localparam logic [4:0] S_AP_WR  = 5'd5;
  localparam logic [4:0] S_CHECK  = 5'd6;
  localparam logic [4:0] S_VISIT  = 5'd7;
  localparam logic [4:0] S_PD_RD  = 5'd8;
  localparam logic [4:0] S_PD_LT  = 5'd9;
  localparam logic [4:0] S_LC_SET = 5'd10;
  localparam logic [4:0] S_RC_SET = 5'd11;
  localparam logic [4:0] S_NEXT   = 5'd12;
  localparam logic [4:0] S_Q_RD   = 5'd13;
  localparam logic [4:0] S_Q_ACC  = 5'd14;
  localparam logic [4:0] S_C_RDL  = 5'd15;
  localparam logic [4:0] S_C_RDR  = 5'd16;
  localparam logic [4:0] S_C_WR   = 5'd17;
  localparam logic [4:0] S_RET    = 5'd18;
  localparam logic [4:0] S_FIN    = 5'd19;

  localparam logic [1:0] RET_INIT = 2'd0;
  localparam logic [1:0] RET_COV  = 2'd1;
  localparam logic [1:0] RET_LC   = 2'd2;
  localparam logic [1:0] RET_RC   = 2'd3;

  logic [4:0] state, state_next;
  logic [1:0] ap_ret, ap_ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      ap_ret <= RET_INIT;
    end else begin
      state  <= state_next;
      ap_ret <= ap_ret_next;
    end
  end

  always_comb begin
    state_next  = state;
    ap_ret_next = ap_ret;
    cmd         = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd        = DP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_INIT: begin
        cmd         = DP_SET_INIT;
        ap_ret_next = RET_INIT;
        state_next  = S_AP_RD;
      end
      S_AP_RD: begin
        cmd        = DP_AP_RD;
        state_next = S_AP_X;
      end
      S_AP_X: begin
        cmd        = DP_AP_X;
        state_next = S_AP_MUL;
      end
      S_AP_MUL: begin
        cmd        = DP_AP_MUL;
        state_next = S_AP_WR;
      end
      S_AP_WR: begin
        cmd = DP_AP_WR;
        unique case (ap_ret)
          RET_INIT: state_next = S_IDLE;
          RET_COV:  state_next = S_RET;
          RET_LC:   state_next = S_RC_SET;
          default:  state_next = S_NEXT;
        endcase
      end
      S_CHECK: begin
        state_next = (st.err || st.op_none) ? S_FIN : S_VISIT;
      end
      S_VISIT: begin
        if (st.covered && st.is_query) begin
          state_next = S_Q_RD;
        end else if (st.covered) begin
          cmd         = DP_SET_COV;
          ap_ret_next = RET_COV;
          state_next  = S_AP_RD;
        end else begin
          state_next = S_PD_RD;
        end
      end
      S_PD_RD: begin
        cmd        = DP_RD_N;
        state_next = S_PD_LT;
      end
      S_PD_LT: begin
        cmd        = DP_PD_LATCH;
        state_next = S_LC_SET;
      end
      S_LC_SET: begin
        cmd         = DP_SET_LC;
        ap_ret_next = RET_LC;
        state_next  = S_AP_RD;
      end
      S_RC_SET: begin
        cmd         = DP_SET_RC;
        ap_ret_next = RET_RC;
        state_next  = S_AP_RD;
      end
      S_NEXT: begin
        if (st.phase == 2'd0) begin
          cmd        = st.go_left ? DP_DESC_L : DP_PH_INC;
          state_next = st.go_left ? S_VISIT : S_NEXT;
        end else if (st.phase == 2'd1) begin
          cmd        = st.go_right ? DP_DESC_R : DP_PH_INC;
          state_next = st.go_right ? S_VISIT : S_NEXT;
        end else begin
          state_next = st.is_query ? S_RET : S_C_RDL;
        end
      end
      S_Q_RD: begin
        cmd        = DP_RD_N;
        state_next = S_Q_ACC;
      end
      S_Q_ACC: begin
        cmd        = DP_ACC;
        state_next = S_RET;
      end
      S_C_RDL: begin
        cmd        = DP_RD_LC;
        state_next = S_C_RDR;
      end
      S_C_RDR: begin
        cmd        = DP_RD_RC;
        state_next = S_C_WR;
      end
      S_C_WR: begin
        cmd        = DP_COMB_WR;
        state_next = S_RET;
      end
      S_RET: begin
        if (st.sp_zero) begin
          state_next = S_FIN;
        end else begin
          cmd        = DP_POP;
          state_next = S_NEXT;
        end
      end
      S_FIN: begin
        cmd        = DP_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // rebuild on any register write
    if (st.cfg_hit) begin
      cmd        = DP_NOP;
      state_next = S_INIT;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: design/raat_dp.sv
// ----------------------------------------------------------------------------
// raat_dp
// Datapath: configuration registers, node memory, node-update unit,
// traversal stack and result registers.
// ----------------------------------------------------------------------------
module raat_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [raat_pkg::CW-1:0] cmd,
  input  logic [1:0]              op,
  input  logic [15:0]             range_low,
  input  logic [15:0]             range_high,
  input  logic [31:0]             operand_value,
  input  logic                    wr_en,
  input  logic [1:0]              wr_index,
  input  logic [31:0]             wr_data,
  output raat_pkg::status_t       st,
  output logic                    result_valid,
  output logic [31:0]             aggregate_result,
  output logic                    range_error
);
  import raat_pkg::*;

  logic [1:0]  mode;
  logic [31:0] def_val;
  logic [15:0] span_start, span_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 2'd0;
      def_val    <= 32'd0;
      span_start <= 16'd0;
      span_end   <= 16'd1023;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_MODE:    mode       <= wr_data[1:0];
        CFG_DEFAULT: def_val    <= wr_data;
        CFG_START:   span_start <= wr_data[15:0];
        default:     span_end   <= wr_data[15:0];
      endcase
    end
  end

  logic is_sum;
  assign is_sum = (mode != MODE_MAX) && (mode != MODE_MIN);

  function automatic logic [31:0] combine(input logic [1:0] m, input logic [31:0] a,
                                          input logic [31:0] b);
    logic [31:0] res;
    case (m)
      MODE_MAX: res = ($signed(a) >= $signed(b)) ? a : b;
      MODE_MIN: res = ($signed(a) <= $signed(b)) ? a : b;
      default:  res = a + b;
    endcase
    return res;
  endfunction

  // item registers
  logic [1:0]    it_op;
  logic [PW-1:0] ql, qr;
  logic [31:0]   it_val;
  logic          it_err;

  logic [16:0] eff_end;
  logic        ld_err;
  always_comb begin
    eff_end = {1'b0, span_start} + 17'(LEAVES - 1);
    if ({1'b0, span_end} < eff_end) eff_end = {1'b0, span_end};
    ld_err = (op != OP_NONE) &&
             ((range_low > range_high) || (range_low < span_start) ||
              ({1'b0, range_high} > eff_end));
  end

  // current node and stack
  logic [NW-1:0]  cur_n;
  logic [PW-1:0]  cur_l, cur_r;
  logic [1:0]     cur_ph;
  logic [SPW-1:0] sp;
  logic [NW-1:0]  stk_n  [SD];
  logic [PW-1:0]  stk_l  [SD];
  logic [PW-1:0]  stk_r  [SD];
  logic [1:0]     stk_ph [SD];
  logic [SPW-1:0] sp_m1;

  logic [PW-1:0] half, mid;
  logic [NW-1:0] lc, rc;
  logic [LW-1:0] len_c, len_l, len_r;

  always_comb begin
    half  = (cur_r - cur_l) >> 1;
    mid   = cur_l + half;
    lc    = cur_n + NW'(1);
    rc    = cur_n + ((NW'(half) + NW'(1)) << 1);
    len_c = LW'(cur_r - cur_l) + LW'(1);
    len_l = LW'(half) + LW'(1);
    len_r = LW'(cur_r - mid);
    sp_m1 = sp - SPW'(1);
  end

  // node memory
  node_t         mem [NODES];
  node_t         rdata, wdata;
  logic [NW-1:0] raddr, waddr;
  logic          we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // node-update unit registers
  logic [NW-1:0] ap_n;
  logic [LW-1:0] ap_len;
  logic          ap_asg;
  logic [31:0]   ap_val, xreg, prod;
  node_t         ereg, pe;
  logic [31:0]   acc, lagg;
  logic          acc_have;

  always_comb begin
    raddr = cur_n;
    case (cmd)
      DP_AP_RD: raddr = ap_n;
      DP_RD_LC: raddr = lc;
      DP_RD_RC: raddr = rc;
      default:  raddr = cur_n;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_n;
    wdata = '0;
    case (cmd)
      DP_AP_WR: begin
        we    = 1'b1;
        waddr = ap_n;
        if (ap_asg || ereg.flag) begin
          wdata.flag = 1'b1;
          wdata.asgv = xreg;
          wdata.padd = 32'd0;
          wdata.agg  = is_sum ? prod : xreg;
        end else begin
          wdata.flag = 1'b0;
          wdata.asgv = ereg.asgv;
          wdata.padd = ereg.padd + ap_val;
          wdata.agg  = ereg.agg + (is_sum ? prod : xreg);
        end
      end
      DP_PD_LATCH: begin
        we        = 1'b1;
        wdata.agg = rdata.agg;
      end
      DP_COMB_WR: begin
        we        = 1'b1;
        wdata.agg = combine(mode, lagg, rdata.agg);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd)
      DP_LOAD: begin
        it_op  <= op;
        ql     <= PW'(range_low - span_start);
        qr     <= PW'(range_high - span_start);
        it_val <= operand_value;
        it_err <= ld_err;
        cur_n  <= '0;
        cur_l  <= '0;
        cur_r  <= PW'(LEAVES - 1);
        cur_ph <= 2'd0;
      end
      DP_SET_INIT: begin
        ap_n   <= '0;
        ap_len <= LW'(LEAVES);
        ap_asg <= 1'b1;
        ap_val <= def_val;
      end
      DP_SET_COV: begin
        ap_n   <= cur_n;
        ap_len <= len_c;
        ap_asg <= (it_op == OP_ASSIGN);
        ap_val <= it_val;
      end
      DP_SET_LC: begin
        ap_n   <= lc;
        ap_len <= len_l;
        ap_asg <= pe.flag;
        ap_val <= pe.flag ? pe.asgv : pe.padd;
      end
      DP_SET_RC: begin
        ap_n   <= rc;
        ap_len <= len_r;
        ap_asg <= pe.flag;
        ap_val <= pe.flag ? pe.asgv : pe.padd;
      end
      DP_AP_X: begin
        ereg <= rdata;
        xreg <= (!ap_asg && rdata.flag) ? rdata.asgv + ap_val : ap_val;
      end
      DP_AP_MUL:   prod <= 32'({{(32-LW){1'b0}}, ap_len} * xreg);
      DP_PD_LATCH: pe   <= rdata;
      DP_ACC:      acc  <= acc_have ? combine(mode, acc, rdata.agg) : rdata.agg;
      DP_RD_RC:    lagg <= rdata.agg;
      DP_DESC_L: begin
        stk_n[sp[SIW-1:0]]  <= cur_n;
        stk_l[sp[SIW-1:0]]  <= cur_l;
        stk_r[sp[SIW-1:0]]  <= cur_r;
        stk_ph[sp[SIW-1:0]] <= 2'd1;
        cur_n  <= lc;
        cur_r  <= mid;
        cur_ph <= 2'd0;
      end
      DP_DESC_R: begin
        stk_n[sp[SIW-1:0]]  <= cur_n;
        stk_l[sp[SIW-1:0]]  <= cur_l;
        stk_r[sp[SIW-1:0]]  <= cur_r;
        stk_ph[sp[SIW-1:0]] <= 2'd2;
        cur_n  <= rc;
        cur_l  <= mid + PW'(1);
        cur_ph <= 2'd0;
      end
      DP_PH_INC: cur_ph <= cur_ph + 2'd1;
      DP_POP: begin
        cur_n  <= stk_n[sp_m1[SIW-1:0]];
        cur_l  <= stk_l[sp_m1[SIW-1:0]];
        cur_r  <= stk_r[sp_m1[SIW-1:0]];
        cur_ph <= stk_ph[sp_m1[SIW-1:0]];
      end
      DP_DONE: begin
        aggregate_result <= (it_op == OP_QUERY && !it_err) ? acc : 32'd0;
        range_error      <= it_err;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= '0;
      acc_have     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd == DP_DONE);
      case (cmd)
        DP_LOAD:   begin
          sp       <= '0;
          acc_have <= 1'b0;
        end
        DP_ACC:    acc_have <= 1'b1;
        DP_DESC_L,
        DP_DESC_R: sp <= sp + SPW'(1);
        DP_POP:    sp <= sp_m1;
        default: ;
      endcase
    end
  end

  always_comb begin
    st.cfg_hit  = wr_en;
    st.err      = it_err;
    st.op_none  = (it_op == OP_NONE);
    st.is_query = (it_op == OP_QUERY);
    st.covered  = (ql <= cur_l) && (cur_r <= qr);
    st.go_left  = (ql <= mid);
    st.go_right = (qr > mid);
    st.phase    = cur_ph;
    st.sp_zero  = (sp == '0);
  end

endmodule

// File: design/range_assign_add_aggregate_tree.sv
// ----------------------------------------------------------------------------
// range_assign_add_aggregate_tree
// Lazy segment tree with range assign, range add and sum/max/min query.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (op, range_low, range_high, operand_value) is
//   taken at a clock edge with start high, busy low and wr_en low.
//   Result channel: result_valid strobes for one cycle with aggregate_result
//   and range_error; the receiver always takes it.
//   Config: wr_en, wr_index, wr_data write one register per cycle; any write
//   rebuilds the tree, during which busy is high.
// Flow:
//   A rejected range or unused op finishes without visiting the tree. A valid
//   word walks the tree one node at a time through the node memory (one read
//   port, one write port), pushing pending tags to both children at each
//   split node, plus a child combine on the way back on update; the tree has
//   1024 leaves. One word in flight.
// Reset:
//   rst restores the register defaults and rebuilds the tree.
// ----------------------------------------------------------------------------
module range_assign_add_aggregate_tree (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [15:0]        range_low,
  input  logic [15:0]        range_high,
  input  logic signed [31:0] operand_value,
  output logic               result_valid,
  output logic signed [31:0] aggregate_result,
  output logic               range_error,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data
);
  import raat_pkg::*;

  status_t       st;
  logic [CW-1:0] cmd;
  logic [31:0]   agg_raw;

  raat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  raat_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .op               (op),
    .range_low        (range_low),
    .range_high       (range_high),
    .operand_value    (operand_value),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .st               (st),
    .result_valid     (result_valid),
    .aggregate_result (agg_raw),
    .range_error      (range_error)
  );

  assign aggregate_result = agg_raw;

`include "range_assign_add_aggregate_tree_assert.svh"

  `RAAT_ASSERT_NEXT(a_accept_busy, start && !busy && !wr_en, busy)
  `RAAT_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)
  `RAAT_ASSERT_NOW(a_error_zero, result_valid && range_error, aggregate_result == 32'sd0)

endmodule
